// ----- src/modexp_pkg.sv -----
// Shared widths and control types for the modular exponentiation block.
package modexp_pkg;
    localparam int MOD_WIDTH = 31;
    localparam int EXP_WIDTH = 63;
    localparam int PROD_WIDTH = 2 * MOD_WIDTH;
    localparam int RED_CNT_WIDTH = $clog2(PROD_WIDTH + 1);
    localparam logic [MOD_WIDTH-1:0] MOD_RESET = {MOD_WIDTH{1'b1}};

    // Multiplication operand selection.
    typedef enum logic [1:0] {
        MUL_REDUCE_BASE = 2'd0,
        MUL_ACC_SQ      = 2'd1,
        MUL_SQ_SQ       = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     write_acc;
        logic     write_sq;
        logic     shift_exp;
    } t_ctrl;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic mod_small;
    } t_status;
endpackage

// ----- src/modexp_datapath.sv -----
// Datapath: operand registers, a full-width multiplier and a bit-serial reduction unit.
module modexp_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  modexp_pkg::t_ctrl                i_ctrl,
    input  logic                             i_op,
    input  logic [modexp_pkg::MOD_WIDTH-1:0] i_base,
    input  logic [modexp_pkg::EXP_WIDTH-1:0] i_exponent,
    input  logic [modexp_pkg::MOD_WIDTH-1:0] i_modulus,
    output modexp_pkg::t_status              o_status,
    output logic [modexp_pkg::MOD_WIDTH-1:0] o_acc
);
    import modexp_pkg::*;

    logic [MOD_WIDTH-1:0]     r_acc, r_sq, r_rem;
    logic [EXP_WIDTH-1:0]     r_exp;
    logic [PROD_WIDTH-1:0]    r_prod;
    logic [RED_CNT_WIDTH-1:0] r_cnt;
    logic                     r_busy;
    logic [MOD_WIDTH-1:0]     w_x, w_y;
    logic [MOD_WIDTH:0]       w_trial, w_diff;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_REDUCE_BASE: begin
                w_x = r_sq;
                w_y = {{(MOD_WIDTH-1){1'b0}}, 1'b1};
            end
            MUL_ACC_SQ: begin
                w_x = r_acc;
                w_y = r_sq;
            end
            default: begin
                w_x = r_sq;
                w_y = r_sq;
            end
        endcase
    end

    // Restoring reduction: one product bit shifts into the remainder per cycle.
    assign w_trial = {r_rem, r_prod[PROD_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_modulus};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_sq  <= i_base;
                r_acc <= {{(MOD_WIDTH-1){1'b0}}, 1'b1};
                r_exp <= i_op ? {{(EXP_WIDTH-MOD_WIDTH){1'b0}},
                                 i_modulus - MOD_WIDTH'(2)} : i_exponent;
            end
            if (i_ctrl.shift_exp) begin
                r_exp <= r_exp >> 1;
            end
            if (i_ctrl.mul_start) begin
                r_prod <= PROD_WIDTH'(w_x) * PROD_WIDTH'(w_y);
                r_rem  <= '0;
                r_cnt  <= RED_CNT_WIDTH'(PROD_WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= r_prod << 1;
                r_rem  <= w_diff[MOD_WIDTH] ? w_trial[MOD_WIDTH-1:0]
                                            : w_diff[MOD_WIDTH-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == RED_CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctrl.write_acc) begin
                r_acc <= r_rem;
            end
            if (i_ctrl.write_sq) begin
                r_sq <= r_rem;
            end
        end
    end

    assign o_status.mul_done  = !r_busy && !i_ctrl.mul_start;
    assign o_status.exp_zero  = (r_exp == '0);
    assign o_status.exp_lsb   = r_exp[0];
    assign o_status.mod_small = (i_modulus[MOD_WIDTH-1:1] == '0);
    assign o_acc = r_acc;
endmodule

// ----- src/modexp_ctrl.sv -----
// Controller state machine sequencing square-and-multiply steps.
module modexp_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  modexp_pkg::t_status              i_status,
    input  logic [modexp_pkg::MOD_WIDTH-1:0] i_acc,
    output modexp_pkg::t_ctrl                o_ctrl,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [modexp_pkg::MOD_WIDTH-1:0] o_residue
);
    import modexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RED_BASE, S_WAIT_BASE, S_CHECK, S_WAIT_MUL, S_WAIT_SQ
    } t_state;

    t_state               r_state;
    t_ctrl                r_ctrl;
    logic                 r_done;
    logic [MOD_WIDTH-1:0] r_residue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctrl  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ctrl  <= '0;
            r_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RED_BASE;
                    end
                end
                S_RED_BASE: begin
                    if (i_status.mod_small) begin
                        r_residue <= '0;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_ctrl.mul_start <= 1'b1;
                        r_ctrl.mul_sel   <= MUL_REDUCE_BASE;
                        r_state          <= S_WAIT_BASE;
                    end
                end
                S_WAIT_BASE: begin
                    if (i_status.mul_done) begin
                        r_ctrl.write_sq <= 1'b1;
                        r_state         <= S_CHECK;
                    end
                end
                // The exponent shifts while the multiplications run, so the
                // next check sees the next bit.
                S_CHECK: begin
                    if (i_status.exp_zero) begin
                        r_residue <= i_acc;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (i_status.exp_lsb) begin
                        r_ctrl.mul_start <= 1'b1;
                        r_ctrl.mul_sel   <= MUL_ACC_SQ;
                        r_ctrl.shift_exp <= 1'b1;
                        r_state          <= S_WAIT_MUL;
                    end else begin
                        r_ctrl.mul_start <= 1'b1;
                        r_ctrl.mul_sel   <= MUL_SQ_SQ;
                        r_ctrl.shift_exp <= 1'b1;
                        r_state          <= S_WAIT_SQ;
                    end
                end
                S_WAIT_MUL: begin
                    if (i_status.mul_done) begin
                        r_ctrl.write_acc <= 1'b1;
                        r_ctrl.mul_start <= 1'b1;
                        r_ctrl.mul_sel   <= MUL_SQ_SQ;
                        r_state          <= S_WAIT_SQ;
                    end
                end
                S_WAIT_SQ: begin
                    if (i_status.mul_done) begin
                        r_ctrl.write_sq <= 1'b1;
                        r_state         <= S_CHECK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The operands are captured at the transfer edge itself, so load is decoded directly.
    always_comb begin
        o_ctrl      = r_ctrl;
        o_ctrl.load = (r_state == S_IDLE) && i_start;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_residue = r_residue;
endmodule

// ----- src/modular_exponentiation.sv -----
// Each request runs a base reduction, one squaring per exponent bit and one product per set
// exponent bit; each multiplication registers the full product and then reduces all 62
// product bits bit-serially before handing off to the controller. Worst case 127
// multiplications.
// One item at a time; busy drops in the o_done cycle, when the next start can transfer.
// Synchronous active-low reset idles the block and sets the modulus to all ones.
module modular_exponentiation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cfg_we,
    input  logic [modexp_pkg::MOD_WIDTH-1:0] i_cfg_data,
    input  logic                             i_op,
    input  logic [modexp_pkg::MOD_WIDTH-1:0] i_base,
    input  logic [modexp_pkg::EXP_WIDTH-1:0] i_exponent,
    output logic                             o_done,
    output logic [modexp_pkg::MOD_WIDTH-1:0] o_residue
);
    import modexp_pkg::*;

    t_ctrl                w_ctrl;
    t_status              w_status;
    logic [MOD_WIDTH-1:0] w_acc;
    logic [MOD_WIDTH-1:0] r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    modexp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_status  (w_status),
        .i_acc     (w_acc),
        .o_ctrl    (w_ctrl),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_residue (o_residue)
    );

    modexp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_op       (i_op),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_modulus  (r_modulus),
        .o_status   (w_status),
        .o_acc      (w_acc)
    );
endmodule

// ----- tb/modular_exponentiation_test.sv -----
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module modular_exponentiation_test;
    import modexp_pkg::*;

    localparam int IDLE_LIMIT = 50000;
    localparam int MAX_REPORTS = 10;
    localparam logic [MOD_WIDTH-1:0] MOD_MAX = {MOD_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_SET_MODULUS,
        JOB_WAIT_EMPTY
    } t_job_kind;

    typedef struct {
        t_job_kind            kind;
        logic                 op;
        logic [MOD_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0] exponent;
    } t_job;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_cfg_we;
    logic [MOD_WIDTH-1:0] i_cfg_data;
    logic                 i_op;
    logic [MOD_WIDTH-1:0] i_base;
    logic [EXP_WIDTH-1:0] i_exponent;
    logic                 o_done;
    logic [MOD_WIDTH-1:0] o_residue;

    t_job                 job_queue[$];
    logic [MOD_WIDTH-1:0] residue_queue[$];
    logic [MOD_WIDTH-1:0] cur_modulus;
    int                   gap_count;
    int                   idle_cycles;
    int                   mismatch_count;
    int                   request_count;
    int                   result_count;
    int                   modulus_writes;

    modular_exponentiation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_op       (i_op),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_done     (o_done),
        .o_residue  (o_residue)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Right-to-left square and multiply; inverse mode uses modulus - 2 as exponent.
    function automatic logic [MOD_WIDTH-1:0] expected_residue(logic op,
            logic [MOD_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e, logic [MOD_WIDTH-1:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] ex;
        if (m < 2) return '0;
        ex = op ? 64'(m) - 64'd2 : 64'(e);
        acc = 64'd1;
        sq = 64'(b) % 64'(m);
        while (ex != 0) begin
            if (ex[0]) acc = (acc * sq) % 64'(m);
            sq = (sq * sq) % 64'(m);
            ex = ex >> 1;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    function automatic void add_request(logic op, logic [MOD_WIDTH-1:0] b,
            logic [EXP_WIDTH-1:0] e);
        t_job j;
        j.kind = JOB_REQUEST;
        j.op = op;
        j.base = b;
        j.exponent = e;
        job_queue = {job_queue, j};
    endfunction

    function automatic void add_control(t_job_kind kind, logic [MOD_WIDTH-1:0] value);
        t_job j;
        j.kind = kind;
        j.op = 1'b0;
        j.base = value;
        j.exponent = '0;
        job_queue = {job_queue, j};
    endfunction

    // Exponents take random lengths so short and long scans both occur.
    function automatic void add_random_requests(int n);
        logic [EXP_WIDTH-1:0] e;
        logic [MOD_WIDTH-1:0] b;
        int len;
        for (int k = 0; k < n; k++) begin
            len = $urandom_range(0, EXP_WIDTH);
            e = EXP_WIDTH'({$urandom, $urandom});
            e = (len == EXP_WIDTH) ? e : e & ((63'd1 << len) - 63'd1);
            case ($urandom_range(0, 5))
                0: b = MOD_WIDTH'($urandom_range(0, 20));
                1: b = MOD_MAX - MOD_WIDTH'($urandom_range(0, 3));
                default: b = MOD_WIDTH'($urandom);
            endcase
            add_request($urandom_range(0, 3) == 0, b, e);
        end
    endfunction

    // Driver: starts requests, writes the modulus only while nothing is pending.
    always @(posedge i_clk) begin
        t_job j;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_count <= 0;
        end else if (start && !busy) begin
            residue_queue = {residue_queue,
                             expected_residue(i_op, i_base, i_exponent, cur_modulus)};
            request_count <= request_count + 1;
            if (job_queue.size() > 0 && job_queue[0].kind == JOB_REQUEST
                    && $urandom_range(0, 3) == 0) begin
                // Back-to-back: the next request follows with start held high.
                j = job_queue.pop_front();
                i_op <= j.op;
                i_base <= j.base;
                i_exponent <= j.exponent;
                gap_count <= 0;
            end else begin
                start <= 1'b0;
                gap_count <= $urandom_range(0, 17);
            end
        end else if (start) begin
            // Waiting for the block to take the request.
        end else if (i_cfg_we) begin
            i_cfg_we <= 1'b0;
        end else if (gap_count > 0) begin
            gap_count <= gap_count - 1;
        end else if (job_queue.size() > 0) begin
            j = job_queue[0];
            case (j.kind)
                JOB_REQUEST: begin
                    void'(job_queue.pop_front());
                    i_op <= j.op;
                    i_base <= j.base;
                    i_exponent <= j.exponent;
                    start <= 1'b1;
                end
                JOB_SET_MODULUS: begin
                    if (residue_queue.size() == 0 && !busy) begin
                        void'(job_queue.pop_front());
                        i_cfg_data <= j.base;
                        i_cfg_we <= 1'b1;
                        cur_modulus <= j.base;
                        modulus_writes <= modulus_writes + 1;
                    end
                end
                default: begin
                    if (residue_queue.size() == 0) void'(job_queue.pop_front());
                end
            endcase
        end
    end

    // Monitor: every done pulse is one result transfer.
    always @(posedge i_clk) begin
        logic [MOD_WIDTH-1:0] exp_res;
        if (i_rst_n && o_done) begin
            result_count <= result_count + 1;
            if (residue_queue.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result residue=%0d", o_residue);
            end else begin
                exp_res = residue_queue.pop_front();
                if (o_residue !== exp_res) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("residue mismatch: expected %0d, got %0d (modulus %0d)",
                                 exp_res, o_residue, cur_modulus);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_op = 1'b0;
        i_base = '0;
        i_exponent = '0;
        cur_modulus = MOD_RESET;
        gap_count = 0;
        idle_cycles = 0;
        mismatch_count = 0;
        request_count = 0;
        result_count = 0;
        modulus_writes = 0;

        // Reset modulus (prime): zero exponents, extremes, inverse mode.
        add_request(1'b0, '0, '0);
        add_request(1'b0, 31'd12345, '0);
        add_request(1'b0, '0, 63'd5);
        add_request(1'b0, MOD_MAX, 63'd3);
        add_request(1'b0, MOD_MAX - 31'd1, {EXP_WIDTH{1'b1}});
        add_request(1'b0, 31'd2, 63'd30);
        add_request(1'b1, 31'd2, 63'd7);
        add_request(1'b1, MOD_MAX - 31'd1, '0);
        add_request(1'b1, '0, {EXP_WIDTH{1'b1}});
        add_request(1'b1, MOD_MAX, '0);
        add_random_requests(20);
        add_control(JOB_WAIT_EMPTY, '0);
        add_random_requests(5);

        // Smallest legal modulus: inverse has a zero exponent.
        add_control(JOB_SET_MODULUS, 31'd2);
        add_request(1'b1, 31'd4, '0);
        add_request(1'b1, 31'd7, '0);
        add_request(1'b0, 31'd3, 63'd9);
        add_random_requests(3);

        // Out-of-range moduli give a zero residue.
        add_control(JOB_SET_MODULUS, 31'd0);
        add_request(1'b0, 31'd5, '0);
        add_request(1'b1, 31'd5, 63'd2);
        add_control(JOB_SET_MODULUS, 31'd1);
        add_request(1'b0, 31'd5, 63'd3);
        add_request(1'b1, '0, '0);

        // Small prime: base above the modulus and multiples of it.
        add_control(JOB_SET_MODULUS, 31'd13);
        add_request(1'b1, 31'd26, '0);
        add_request(1'b1, 31'd40, '0);
        add_request(1'b0, 31'd100, 63'd12);
        add_random_requests(12);

        add_control(JOB_SET_MODULUS, 31'($urandom_range(2, 32'h7fff_ffff)));
        add_random_requests(15);
        add_control(JOB_SET_MODULUS, 31'd1000000007);
        add_random_requests(10);
        add_control(JOB_SET_MODULUS, MOD_MAX);
        add_random_requests(8);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_queue.size() != 0 || start || residue_queue.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("%0d requests and %0d results over %0d modulus settings,", request_count,
                 result_count, modulus_writes + 1);
        $display("power and inverse modes, zero and full-width exponents, out-of-range moduli.");
        if (mismatch_count == 0 && residue_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/modexp_pkg.sv
src/modexp_datapath.sv
src/modexp_ctrl.sv
src/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
